@@ rtl/pexp_pkg.sv @@
`timescale 1ns / 1ps
// Package for the precedence expression evaluator: token kinds, status codes,
// product operation codes and the command and status structs between the
// controller and the datapath. No dependencies.
package pexp_pkg;

	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [2:0] K_NUM = 3'd0;
	localparam logic [2:0] K_ADD = 3'd1;
	localparam logic [2:0] K_SUB = 3'd2;
	localparam logic [2:0] K_MUL = 3'd3;
	localparam logic [2:0] K_DIV = 3'd4;
	localparam logic [2:0] K_END = 3'd5;
	localparam logic [2:0] K_CLR = 3'd6;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIV0 = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	localparam logic [1:0] POP_NONE = 2'd0;
	localparam logic [1:0] POP_MUL  = 2'd1;
	localparam logic [1:0] POP_DIV  = 2'd2;

	typedef struct packed {
		logic term_load;
		logic mul_start;
		logic div_start;
		logic fold;
		logic sub;
		logic clear;
		logic capture;
		logic ok;
	} pexp_cmd_t;

	typedef struct packed {
		logic v_zero;
		logic done;
	} pexp_sts_t;

endpackage

@@ rtl/pexp_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for token items and result items.
// Depends on nothing; widths are fixed by the token and result formats.
interface pexp_tok_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  kind;
	logic signed [31:0] value;

	modport source (output valid, kind, value, input ready);
	modport sink   (input valid, kind, value, output ready);
endinterface

interface pexp_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result;
	logic        [1:0]  status;

	modport source (output valid, result, status, input ready);
	modport sink   (input valid, result, status, output ready);
endinterface

@@ rtl/pexp_dp.sv @@
`timescale 1ns / 1ps
// Datapath: running sum, current term, a shared shift-add multiplier and
// restoring divider, and the result register. Depends on pexp_pkg.
module pexp_dp #(
	parameter int DATA_WIDTH = pexp_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic signed [31:0]    value,
	input  pexp_pkg::pexp_cmd_t   cmd,
	output pexp_pkg::pexp_sts_t   sts,
	output logic signed [31:0]    result
);
	import pexp_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int CW = $clog2(DW + 1);

	logic signed [DW-1:0] v;
	logic signed [DW-1:0] sum_q;
	logic signed [DW-1:0] term_q;
	logic signed [DW-1:0] fold;
	logic        [DW-1:0] a_q;
	logic        [DW-1:0] b_q;
	logic        [DW:0]   p_q;
	logic                 mul_q;
	logic                 neg_q;
	logic                 busy_q;
	logic        [CW-1:0] cnt_q;
	logic        [DW:0]   rem_sh;
	logic                 fits;
	logic        [DW-1:0] term_mag;
	logic        [DW-1:0] v_mag;
	logic                 done;
	logic signed [31:0]   result_q;

	assign v        = DW'(value);
	assign fold     = cmd.sub ? (sum_q - term_q) : (sum_q + term_q);
	assign term_mag = term_q[DW-1] ? DW'(-term_q) : term_q;
	assign v_mag    = v[DW-1] ? DW'(-v) : v;
	assign rem_sh   = {p_q[DW-1:0], a_q[DW-1]};
	assign fits     = (rem_sh >= {1'b0, b_q});
	assign done     = busy_q && (cnt_q == '0);

	assign sts.v_zero = (v == '0);
	assign sts.done   = done;
	assign result     = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			term_q <= '0;
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (cmd.term_load) begin
				term_q <= v;
			end
			if (cmd.fold) begin
				sum_q  <= fold;
				term_q <= '0;
			end
			if (cmd.mul_start || cmd.div_start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
				if (mul_q) begin
					term_q <= p_q[DW-1:0];
				end else begin
					term_q <= neg_q ? DW'(-a_q) : a_q;
				end
			end
			if (cmd.clear) begin
				sum_q  <= '0;
				term_q <= '0;
			end
		end
	end

	// Operand registers of the iterative unit: one bit of the multiplier
	// or one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mul_q <= 1'b1;
			a_q   <= v;
			b_q   <= term_q;
			p_q   <= '0;
		end else if (cmd.div_start) begin
			mul_q <= 1'b0;
			neg_q <= term_q[DW-1] ^ v[DW-1];
			a_q   <= term_mag;
			b_q   <= v_mag;
			p_q   <= '0;
		end else if (busy_q && cnt_q != '0) begin
			if (mul_q) begin
				p_q <= (DW+1)'(p_q + (a_q[0] ? {1'b0, b_q} : '0));
				b_q <= {b_q[DW-2:0], 1'b0};
				a_q <= {1'b0, a_q[DW-1:1]};
			end else if (fits) begin
				p_q <= rem_sh - {1'b0, b_q};
				a_q <= {a_q[DW-2:0], 1'b1};
			end else begin
				p_q <= rem_sh;
				a_q <= {a_q[DW-2:0], 1'b0};
			end
		end
		if (cmd.capture) begin
			result_q <= cmd.ok ? 32'(fold) : '0;
		end
	end

endmodule

@@ rtl/pexp_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: token decoding, the expected-token and pending-operator state,
// the latched error code and the result handshake. Depends on pexp_pkg.
module pexp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tok_valid,
	output logic                 tok_ready,
	input  logic [2:0]           kind,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output pexp_pkg::pexp_cmd_t  cmd,
	input  pexp_pkg::pexp_sts_t  sts
);
	import pexp_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ARITH = 2'd1;
	localparam logic [1:0] S_EMIT  = 2'd2;

	logic [1:0] state_q;
	logic       sign_q;
	logic [1:0] pop_q;
	logic       expect_q;
	logic [1:0] err_q;
	logic       out_valid_q;
	logic [1:0] status_q;
	logic       accept;
	logic       slot_free;

	assign tok_ready = (state_q == S_IDLE);
	assign accept    = tok_valid && tok_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign status    = status_q;

	always_comb begin
		cmd     = '0;
		cmd.sub = sign_q;
		cmd.ok  = (err_q == ST_OK);
		if (accept) begin
			unique case (kind)
				K_NUM: begin
					if (expect_q) begin
						cmd.mul_start = (pop_q == POP_MUL);
						cmd.div_start = (pop_q == POP_DIV) && !sts.v_zero;
						cmd.term_load = (pop_q == POP_NONE);
					end
				end
				K_ADD, K_SUB: begin
					cmd.fold = !expect_q;
				end
				K_CLR: begin
					cmd.clear = 1'b1;
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_EMIT && slot_free) begin
			cmd.capture = 1'b1;
			cmd.clear   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sign_q      <= 1'b0;
			pop_q       <= POP_NONE;
			expect_q    <= 1'b1;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			// In the emit state the valid flag is either reloaded or held below.
			if (out_valid_q && out_ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (kind)
							K_NUM: begin
								if (!expect_q) begin
									if (err_q == ST_OK) err_q <= ST_BAD;
								end else begin
									pop_q    <= POP_NONE;
									expect_q <= 1'b0;
									if (pop_q == POP_DIV && sts.v_zero) begin
										if (err_q == ST_OK) err_q <= ST_DIV0;
									end else if (pop_q != POP_NONE) begin
										state_q <= S_ARITH;
									end
								end
							end
							K_ADD, K_SUB: begin
								if (expect_q) begin
									if (err_q == ST_OK) err_q <= ST_BAD;
								end else begin
									sign_q   <= (kind == K_SUB);
									pop_q    <= POP_NONE;
									expect_q <= 1'b1;
								end
							end
							K_MUL, K_DIV: begin
								if (expect_q) begin
									if (err_q == ST_OK) err_q <= ST_BAD;
								end else begin
									pop_q    <= (kind == K_MUL) ? POP_MUL : POP_DIV;
									expect_q <= 1'b1;
								end
							end
							K_END: begin
								if (expect_q && err_q == ST_OK) begin
									err_q <= ST_BAD;
								end
								state_q <= S_EMIT;
							end
							K_CLR: begin
								sign_q   <= 1'b0;
								pop_q    <= POP_NONE;
								expect_q <= 1'b1;
								err_q    <= ST_OK;
							end
							default: begin
								if (err_q == ST_OK) err_q <= ST_BAD;
							end
						endcase
					end
				end
				S_ARITH: begin
					if (sts.done) begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					// The result waits here until the output register is free.
					if (slot_free) begin
						out_valid_q <= 1'b1;
						status_q    <= err_q;
						sign_q      <= 1'b0;
						pop_q       <= POP_NONE;
						expect_q    <= 1'b1;
						err_q       <= ST_OK;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/precedence_expression_evaluator.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Payload          Carries
// tok       in         kind, value      one token item per handshake
// res       out        result, status   one result item per end token
//
// Number, operator, end and clear tokens are taken without a wait; a number that
// completes a multiply or a divide by a nonzero value stalls the token channel
// while the shared one-bit-per-cycle multiplier and divider runs.
// An end token moves to the emit state to load the output register, and waits
// there while an earlier result item has not been taken; tokens stall meanwhile.
// Reset clears the sum, the term, the error code and the output valid flag.
// Top level: controller and datapath. Depends on pexp_pkg, pexp_if, pexp_ctrl, pexp_dp.
module precedence_expression_evaluator #(
	parameter int DATA_WIDTH = pexp_pkg::DATA_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	pexp_tok_if.sink          tok,
	pexp_res_if.source        res
);
	import pexp_pkg::*;

	pexp_cmd_t cmd;
	pexp_sts_t sts;

	pexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok.valid),
		.tok_ready (tok.ready),
		.kind      (tok.kind),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.status    (res.status),
		.cmd       (cmd),
		.sts       (sts)
	);

	pexp_dp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (tok.value),
		.cmd    (cmd),
		.sts    (sts),
		.result (res.result)
	);

endmodule

@@ rtl/pexp_chk.sv @@
`timescale 1ns / 1ps
// Port-level checks for the precedence expression evaluator, bound to the top
// level. Depends on pexp_pkg for the status codes.
module pexp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        tok_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_result,
	input logic [1:0]  res_status
);
	import pexp_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_result) && $stable(res_status))
		else $error("result item changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_status == ST_OK || res_status == ST_DIV0 || res_status == ST_BAD))
		else $error("result status code out of range");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != ST_OK |-> res_result == '0)
		else $error("failed result item carries a nonzero value");

	a_emit_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(tok_ready))
		else $error("result item appeared without the end token being processed");

endmodule

bind precedence_expression_evaluator pexp_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.tok_ready  (tok.ready),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_result (res.result),
	.res_status (res.status)
);

@@ tb/tb_precedence_expression_evaluator.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the precedence expression evaluator: token items are driven
// with random idling and stalls, and every result item is checked against a predictor.
// Depends on pexp_pkg, pexp_if and precedence_expression_evaluator.
module tb_precedence_expression_evaluator;
	import pexp_pkg::*;

	localparam logic [2:0] K_UNUSED = 3'd7;
	localparam logic [31:0] INT_MIN = 32'h8000_0000;
	localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
	localparam int SEGMENT = 424;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [31:0] result;
		logic [1:0]  status;
	} answer_t;

	// Tracks the running sum and the term under construction, and queues the answer
	// that each end token should produce.
	class infix_eval_tracker;
		logic [31:0] sum_acc;
		logic [31:0] term_acc;
		logic        neg_pending;
		logic [1:0]  prod_op;
		logic        want_number;
		logic [1:0]  latched_status;
		answer_t     expected_answers[$];
		int          mismatches;

		function new();
			clear_state();
			mismatches = 0;
		endfunction

		function void clear_state();
			sum_acc        = '0;
			term_acc       = '0;
			neg_pending    = 1'b0;
			prod_op        = POP_NONE;
			want_number    = 1'b1;
			latched_status = ST_OK;
		endfunction

		// Only the first error of an expression is kept.
		function void raise(logic [1:0] code);
			if (latched_status == ST_OK)
				latched_status = code;
		endfunction

		function logic [31:0] folded();
			return neg_pending ? sum_acc - term_acc : sum_acc + term_acc;
		endfunction

		function void take_token(logic [2:0] kind, logic [31:0] value);
			logic [31:0] mag_a;
			logic [31:0] mag_b;
			logic [31:0] quot;
			answer_t     ans;
			case (kind)
				K_NUM: begin
					if (!want_number) begin
						raise(ST_BAD);
					end else begin
						if (prod_op == POP_MUL) begin
							term_acc = term_acc * value;
						end else if (prod_op == POP_DIV) begin
							if (value == '0) begin
								raise(ST_DIV0);
							end else begin
								// Divide the magnitudes, then apply the sign: truncation toward zero.
								mag_a = term_acc[31] ? -term_acc : term_acc;
								mag_b = value[31] ? -value : value;
								quot  = mag_a / mag_b;
								if (term_acc[31] ^ value[31])
									quot = -quot;
								term_acc = quot;
							end
						end else begin
							term_acc = value;
						end
						prod_op     = POP_NONE;
						want_number = 1'b0;
					end
				end
				K_ADD, K_SUB: begin
					if (want_number) begin
						raise(ST_BAD);
					end else begin
						sum_acc     = folded();
						term_acc    = '0;
						neg_pending = (kind == K_SUB);
						prod_op     = POP_NONE;
						want_number = 1'b1;
					end
				end
				K_MUL, K_DIV: begin
					if (want_number) begin
						raise(ST_BAD);
					end else begin
						prod_op     = (kind == K_MUL) ? POP_MUL : POP_DIV;
						want_number = 1'b1;
					end
				end
				K_END: begin
					if (want_number)
						raise(ST_BAD);
					ans.status = latched_status;
					ans.result = (latched_status == ST_OK) ? folded() : '0;
					expected_answers.push_back(ans);
					clear_state();
				end
				K_CLR: begin
					clear_state();
				end
				default: begin
					raise(ST_BAD);
				end
			endcase
		endfunction

		function void match_result(logic [31:0] result, logic [1:0] status);
			answer_t ans;
			if (expected_answers.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result item, expected none, actual result %0d status %0d",
					$time, $signed(result), status);
			end else begin
				ans = expected_answers.pop_front();
				if (result !== ans.result) begin
					mismatches++;
					$display("%0t: result mismatch, expected %0d, actual %0d",
						$time, $signed(ans.result), $signed(result));
				end
				if (status !== ans.status) begin
					mismatches++;
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, ans.status, status);
				end
			end
		endfunction

		function int pending();
			return expected_answers.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pexp_tok_if tok ();
	pexp_res_if res ();

	precedence_expression_evaluator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tok    (tok),
		.res    (res)
	);

	infix_eval_tracker tracker = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles   = 0;
	int tokens_sent   = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver: random back-pressure, plus a long hold-off when one is requested.
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				res.ready <= 1'b0;
				hold_cycles--;
			end else begin
				res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			tracker.match_result(res.result, res.status);
	end

	// Offers one token item, with random idle cycles first, and notes it once accepted.
	task automatic send_token(logic [2:0] kind, logic [31:0] value);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			tok.valid <= 1'b0;
			@(negedge clk);
		end
		tok.valid <= 1'b1;
		tok.kind  <= kind;
		tok.value <= value;
		do
			@(posedge clk);
		while (!tok.ready);
		tracker.take_token(kind, value);
		tokens_sent++;
	endtask

	// Operands lean towards zero, one, the extremes and small values.
	function automatic logic [31:0] pick_operand();
		int near;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 32'd1;
			2: return '1;
			3: return INT_MIN;
			4: return INT_MAX;
			5, 6: begin
				near = $urandom_range(0, 40);
				return near - 20;
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic send_expression();
		int          terms;
		logic [2:0]  op;
		terms = $urandom_range(1, 5);
		send_token(K_NUM, pick_operand());
		for (int i = 1; i < terms; i++) begin
			case ($urandom_range(0, 3))
				0: op = K_ADD;
				1: op = K_SUB;
				2: op = K_MUL;
				default: op = K_DIV;
			endcase
			send_token(op, $urandom);
			send_token(K_NUM, pick_operand());
		end
		if ($urandom_range(0, 19) == 0)
			send_token(K_CLR, $urandom);
		else
			send_token(K_END, $urandom);
	endtask

	// Broken sequences: tokens of any kind in any order.
	task automatic send_noise();
		int count;
		count = $urandom_range(1, 6);
		repeat (count)
			send_token(3'($urandom_range(0, 7)), pick_operand());
		if ($urandom_range(0, 1) == 0)
			send_token(K_END, $urandom);
	endtask

	task automatic drain();
		@(negedge clk);
		tok.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n    = 1'b0;
		tok.valid = 1'b0;
		tok.kind  = K_NUM;
		tok.value = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty expression.
		send_token(K_END, '0);
		// Precedence, truncation toward zero and wrap on add: -7 - 20 / -3 * 2 + max.
		send_token(K_NUM, -32'sd7);
		send_token(K_SUB, '0);
		send_token(K_NUM, 32'd20);
		send_token(K_DIV, '0);
		send_token(K_NUM, -32'sd3);
		send_token(K_MUL, '0);
		send_token(K_NUM, 32'd2);
		send_token(K_ADD, '0);
		send_token(K_NUM, INT_MAX);
		send_token(K_END, '0);
		// Minimum divided by minus one.
		send_token(K_NUM, INT_MIN);
		send_token(K_DIV, '0);
		send_token(K_NUM, '1);
		send_token(K_END, '0);
		// Division by zero, then a number out of place: the first error is kept.
		send_token(K_NUM, 32'd5);
		send_token(K_DIV, '0);
		send_token(K_NUM, '0);
		send_token(K_NUM, 32'd3);
		send_token(K_END, '0);
		// Leading operator and the unused kind, wiped by a clear; then a wrapping
		// product and a trailing operator.
		send_token(K_ADD, '1);
		send_token(K_UNUSED, '1);
		send_token(K_CLR, '0);
		send_token(K_NUM, INT_MIN);
		send_token(K_MUL, '0);
		send_token(K_NUM, INT_MIN);
		send_token(K_MUL, '0);
		send_token(K_END, '0);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 29;
					recv_idle_pct = 81;
				end
				1: begin
					send_idle_pct = 81;
					recv_idle_pct = 29;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					// The sender keeps offering items so that the block fills and stalls.
					hold_cycles = 400;
				end
			endcase
			while (tokens_sent < 28 + (phase + 1) * SEGMENT) begin
				if ($urandom_range(0, 6) == 0)
					send_noise();
				else
					send_expression();
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
rtl/pexp_pkg.sv
rtl/pexp_if.sv
rtl/pexp_dp.sv
rtl/pexp_ctrl.sv
rtl/precedence_expression_evaluator.sv
rtl/pexp_chk.sv
tb/tb_precedence_expression_evaluator.sv
